// ----- src/brc_pkg.sv -----
package brc_pkg;

  localparam int unsigned IdxW     = 48;
  localparam int unsigned CntW     = 49;
  localparam int unsigned ByteW    = 64;
  localparam int unsigned SizeW    = 32;
  localparam int unsigned AssetW   = 48;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned HalfW    = 32;

  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = $clog2(QDepth);
  localparam int unsigned ResDepth = 2;
  localparam int unsigned RPtrW    = $clog2(ResDepth);

  localparam logic [CfgIdxW-1:0] RegBlockSize       = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegAssetSize       = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegMaxGapBlocks    = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegMaxRequestBytes = CfgIdxW'(3);

  localparam logic [SizeW-1:0]  BlockSizeRst       = SizeW'(65536);
  localparam logic [AssetW-1:0] AssetSizeRst       = AssetW'(0);
  localparam logic [SizeW-1:0]  MaxGapBlocksRst    = SizeW'(0);
  localparam logic [AssetW-1:0] MaxRequestBytesRst = AssetW'(16777216);

  typedef struct packed {
    logic [SizeW-1:0]  block_size;
    logic [AssetW-1:0] asset_size;
    logic [SizeW-1:0]  max_gap_blocks;
    logic [AssetW-1:0] max_request_bytes;
  } cfg_t;

  typedef struct packed {
    logic [IdxW-1:0]  block_index;
    logic             list_end;
    logic [ByteW-1:0] offset;
    logic [ByteW-1:0] ext_end;
  } item_t;

  typedef struct packed {
    logic [IdxW-1:0]  first_block;
    logic [CntW-1:0]  block_count;
    logic [ByteW-1:0] byte_offset;
    logic [ByteW-1:0] byte_length;
    logic             final_run;
  } result_t;

endpackage

// ----- src/brc_front.sv -----
module brc_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  brc_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [brc_pkg::IdxW-1:0]  block_index_i,
  input  logic                      list_end_i,
  output logic                      item_valid_o,
  input  logic                      item_ready_i,
  output brc_pkg::item_t            item_o
);

  logic                        s1_v_q, s2_v_q, s3_v_q;
  logic                        s1_rdy, s2_rdy, s3_rdy;
  logic [brc_pkg::IdxW-1:0]    s1_idx_q, s2_idx_q, s3_idx_q;
  logic                        s1_last_q, s2_last_q, s3_last_q;
  logic [brc_pkg::ByteW-1:0]   p0_d, s1_p0_q;
  logic [brc_pkg::HalfW-1:0]   p1_d;
  logic [brc_pkg::HalfW-1:0]   s1_p1_q;
  logic [brc_pkg::ByteW-1:0]   off_d, s2_off_q, s3_off_q;
  logic                        ge_d, s3_ge_q;
  logic [brc_pkg::AssetW:0]    sum_d, s3_sum_q;
  logic [brc_pkg::ByteW-1:0]   end_val;

  assign p0_d    = block_index_i[brc_pkg::HalfW-1:0] * cfg_i.block_size;
  assign p1_d    = block_index_i[brc_pkg::IdxW-1:brc_pkg::HalfW] * cfg_i.block_size;
  assign off_d   = s1_p0_q + {s1_p1_q, {brc_pkg::HalfW{1'b0}}};
  assign ge_d    = s2_off_q >= brc_pkg::ByteW'(cfg_i.asset_size);
  assign sum_d   = {1'b0, s2_off_q[brc_pkg::AssetW-1:0]}
                 + (brc_pkg::AssetW+1)'(cfg_i.block_size);

  assign s3_rdy     = !s3_v_q || item_ready_i;
  assign s2_rdy     = !s2_v_q || s3_rdy;
  assign s1_rdy     = !s1_v_q || s2_rdy;
  assign in_ready_o = s1_rdy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= in_valid_i;
      if (s2_rdy) s2_v_q <= s1_v_q;
      if (s3_rdy) s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy) begin
      s1_idx_q  <= block_index_i;
      s1_last_q <= list_end_i;
      s1_p0_q   <= p0_d;
      s1_p1_q   <= p1_d;
    end
    if (s2_rdy) begin
      s2_idx_q  <= s1_idx_q;
      s2_last_q <= s1_last_q;
      s2_off_q  <= off_d;
    end
    if (s3_rdy) begin
      s3_idx_q  <= s2_idx_q;
      s3_last_q <= s2_last_q;
      s3_off_q  <= s2_off_q;
      s3_ge_q   <= ge_d;
      s3_sum_q  <= sum_d;
    end
  end

  // Below the asset end the clipped extent ends at min(offset + size, asset size).
  always_comb begin
    if (s3_ge_q) begin
      end_val = s3_off_q;
    end else if (s3_sum_q < {1'b0, cfg_i.asset_size}) begin
      end_val = brc_pkg::ByteW'(s3_sum_q);
    end else begin
      end_val = brc_pkg::ByteW'(cfg_i.asset_size);
    end
  end

  assign item_valid_o       = s3_v_q;
  assign item_o.block_index = s3_idx_q;
  assign item_o.list_end    = s3_last_q;
  assign item_o.offset      = s3_off_q;
  assign item_o.ext_end     = end_val;

endmodule

// ----- src/brc_queue.sv -----
module brc_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  brc_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output brc_pkg::item_t pop_item_o
);

  brc_pkg::item_t             mem_q [brc_pkg::QDepth];
  logic [brc_pkg::QPtrW-1:0]  wr_q, rd_q;
  logic [brc_pkg::QPtrW:0]    cnt_q;
  logic                       push, pop;

  assign push_ready_o = cnt_q != (brc_pkg::QPtrW+1)'(brc_pkg::QDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_item_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + {{brc_pkg::QPtrW{1'b0}}, push} - {{brc_pkg::QPtrW{1'b0}}, pop};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_item_i;
  end

endmodule

// ----- src/brc_back.sv -----
module brc_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  brc_pkg::cfg_t    cfg_i,
  input  logic             item_valid_i,
  output logic             item_ready_o,
  input  brc_pkg::item_t   item_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output brc_pkg::result_t result_o
);

  logic                        open_q;
  logic [brc_pkg::IdxW-1:0]    first_q, last_q;
  logic [brc_pkg::ByteW-1:0]   first_off_q, last_end_q;

  brc_pkg::result_t            res_q [brc_pkg::ResDepth];
  logic [brc_pkg::RPtrW-1:0]   rd_q, wa0, wa1;
  logic [brc_pkg::RPtrW:0]     cnt_q, space, n_res;

  logic [brc_pkg::IdxW-1:0]    gap;
  logic [brc_pkg::ByteW-1:0]   merged;
  logic                        join_run, close_run, fire, pop;
  logic [brc_pkg::IdxW-1:0]    nf;
  logic [brc_pkg::ByteW-1:0]   nfo;
  brc_pkg::result_t            closed_res, final_res, res_a;

  function automatic brc_pkg::result_t make_result(
    input logic [brc_pkg::IdxW-1:0]  first,
    input logic [brc_pkg::IdxW-1:0]  last,
    input logic [brc_pkg::ByteW-1:0] off,
    input logic [brc_pkg::ByteW-1:0] ext_end,
    input logic                      fin
  );
    brc_pkg::result_t r;
    r.first_block = first;
    r.block_count = {1'b0, last} - {1'b0, first} + brc_pkg::CntW'(1);
    r.byte_offset = off;
    r.byte_length = ext_end - off;
    r.final_run   = fin;
    return r;
  endfunction

  assign gap       = item_i.block_index - last_q - brc_pkg::IdxW'(1);
  assign merged    = item_i.ext_end - first_off_q;
  assign join_run  = open_q && (item_i.block_index > last_q)
                  && (gap <= brc_pkg::IdxW'(cfg_i.max_gap_blocks))
                  && (merged <= brc_pkg::ByteW'(cfg_i.max_request_bytes));
  assign close_run = open_q && !join_run;

  assign nf  = join_run ? first_q : item_i.block_index;
  assign nfo = join_run ? first_off_q : item_i.offset;

  assign closed_res = make_result(first_q, last_q, first_off_q, last_end_q, 1'b0);
  assign final_res  = make_result(nf, item_i.block_index, nfo, item_i.ext_end, 1'b1);
  assign res_a      = close_run ? closed_res : final_res;

  assign n_res = {{brc_pkg::RPtrW{1'b0}}, close_run}
               + {{brc_pkg::RPtrW{1'b0}}, item_i.list_end};

  assign out_valid_o  = cnt_q != '0;
  assign result_o     = res_q[rd_q];
  assign pop          = out_valid_o && out_ready_i;
  assign space        = (brc_pkg::RPtrW+1)'(brc_pkg::ResDepth) - cnt_q
                      + {{brc_pkg::RPtrW{1'b0}}, pop};
  assign item_ready_o = n_res <= space;
  assign fire         = item_valid_i && item_ready_o;

  assign wa0 = rd_q + cnt_q[brc_pkg::RPtrW-1:0];
  assign wa1 = wa0 + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= 1'b0;
      rd_q   <= '0;
      cnt_q  <= '0;
    end else begin
      if (fire) open_q <= !item_i.list_end;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q - {{brc_pkg::RPtrW{1'b0}}, pop} + (fire ? n_res : '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      first_q     <= nf;
      last_q      <= item_i.block_index;
      first_off_q <= nfo;
      last_end_q  <= item_i.ext_end;
      if (n_res != '0) res_q[wa0] <= res_a;
      if (n_res == (brc_pkg::RPtrW+1)'(2)) res_q[wa1] <= final_res;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (brc_pkg::RPtrW+1)'(brc_pkg::ResDepth))
    else $error("Result buffer holds more entries than it has.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && item_i.list_end |=> !open_q)
    else $error("Run still open after the last item of a list.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !item_i.list_end |=> open_q)
    else $error("No run open after an item inside a list.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && (n_res != '0) |=> out_valid_o)
    else $error("Emitted run is not offered at the output.");

endmodule

// ----- src/block_run_coalescer_unit.sv -----
// Items pass the three front stages and the item queue; each result is registered in a result slot.
// Throughput: one item per cycle unless stalled, set by the three-stage multiply and clip pipeline.
// An item that both closes a run and ends its list yields two results, offered one after the other.
// A four-entry queue separates the extent pipeline from the run logic, which owns two result slots.
// Reset clears all valid flags, both queues and the open run at once; no clearing pass follows.
// Configuration registers return to their reset values on reset.
module block_run_coalescer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [brc_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [brc_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [brc_pkg::IdxW-1:0]      block_index_i,
  input  logic                          list_end_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [brc_pkg::IdxW-1:0]      first_block_o,
  output logic [brc_pkg::CntW-1:0]      block_count_o,
  output logic [brc_pkg::ByteW-1:0]     byte_offset_o,
  output logic [brc_pkg::ByteW-1:0]     byte_length_o,
  output logic                          final_run_o
);

  brc_pkg::cfg_t    cfg_q;
  logic             fi_valid, fi_ready, qb_valid, qb_ready;
  brc_pkg::item_t   fi_item, qb_item;
  brc_pkg::result_t result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.block_size        <= brc_pkg::BlockSizeRst;
      cfg_q.asset_size        <= brc_pkg::AssetSizeRst;
      cfg_q.max_gap_blocks    <= brc_pkg::MaxGapBlocksRst;
      cfg_q.max_request_bytes <= brc_pkg::MaxRequestBytesRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        brc_pkg::RegBlockSize: begin
          cfg_q.block_size <= cfg_data_i[brc_pkg::SizeW-1:0];
        end
        brc_pkg::RegAssetSize: begin
          cfg_q.asset_size <= cfg_data_i[brc_pkg::AssetW-1:0];
        end
        brc_pkg::RegMaxGapBlocks: begin
          cfg_q.max_gap_blocks <= cfg_data_i[brc_pkg::SizeW-1:0];
        end
        brc_pkg::RegMaxRequestBytes: begin
          cfg_q.max_request_bytes <= cfg_data_i[brc_pkg::AssetW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  brc_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .block_index_i (block_index_i),
    .list_end_i    (list_end_i),
    .item_valid_o  (fi_valid),
    .item_ready_i  (fi_ready),
    .item_o        (fi_item)
  );

  brc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fi_valid),
    .push_ready_o (fi_ready),
    .push_item_i  (fi_item),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_item_o   (qb_item)
  );

  brc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (qb_valid),
    .item_ready_o (qb_ready),
    .item_i       (qb_item),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_o     (result)
  );

  assign first_block_o = result.first_block;
  assign block_count_o = result.block_count;
  assign byte_offset_o = result.byte_offset;
  assign byte_length_o = result.byte_length;
  assign final_run_o   = result.final_run;

endmodule
